// File: rtl/symbol_table_label_lookup_core_assert.svh
// Assertion macros for the symbol table top level.
`ifndef SYMBOL_TABLE_LABEL_LOOKUP_CORE_ASSERT_SVH
`define SYMBOL_TABLE_LABEL_LOOKUP_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define STLL_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define STLL_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/stll_pkg.sv
// Types and codes shared by the symbol table cells and top level.
`default_nettype none

package stll_pkg;

  localparam int LABEL_LOW_W  = 64;
  localparam int LABEL_HIGH_W = 8;
  localparam int ADDR_W       = 16;

  typedef enum logic [2:0] {
    FUNC_INSERT      = 3'd0,
    FUNC_DELETE      = 3'd1,
    FUNC_SEARCH      = 3'd2,
    FUNC_RENAME      = 3'd3,
    FUNC_SET_ADDR    = 3'd4,
    FUNC_RENAME_ADDR = 3'd5
  } func_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_DUP     = 2'd1,
    STAT_MISSING = 2'd2,
    STAT_FULL    = 2'd3
  } stat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } state_t;

  // Running results carried along the chain with the scan token.
  typedef struct packed {
    logic hit;    // request label seen
    logic free;   // empty slot seen
    logic other;  // new label seen
  } scan_flags_t;

  // Broadcast write to the cell selected by the write index.
  typedef struct packed {
    logic set_valid;
    logic clr_valid;
    logic wr_label;
    logic wr_addr;
  } wr_cmd_t;

endpackage

`default_nettype wire

// File: rtl/stll_cell.sv
// One table slot: stores a label and address, folds its compare into the passing scan token.
`default_nettype none

module stll_cell #(
  parameter int ENTRIES = 32,
  parameter int INDEX   = 0,
  localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // scan token from the left neighbor
  input  wire logic                              tok_in,
  input  wire stll_pkg::scan_flags_t             flags_in,
  input  wire logic [IDX_W-1:0]                  hit_idx_in,
  input  wire logic [IDX_W-1:0]                  free_idx_in,
  input  wire logic [IDX_W-1:0]                  other_idx_in,
  // scan token to the right neighbor
  output logic                                   tok_out,
  output stll_pkg::scan_flags_t                  flags_out,
  output logic [IDX_W-1:0]                       hit_idx_out,
  output logic [IDX_W-1:0]                       free_idx_out,
  output logic [IDX_W-1:0]                       other_idx_out,
  // request labels, held for the whole scan
  input  wire logic [stll_pkg::LABEL_LOW_W-1:0]  req_lo,
  input  wire logic [stll_pkg::LABEL_HIGH_W-1:0] req_hi,
  input  wire logic [stll_pkg::LABEL_LOW_W-1:0]  new_lo,
  input  wire logic [stll_pkg::LABEL_HIGH_W-1:0] new_hi,
  // write broadcast
  input  wire stll_pkg::wr_cmd_t                 wr_cmd,
  input  wire logic [IDX_W-1:0]                  wr_idx,
  input  wire logic [stll_pkg::LABEL_LOW_W-1:0]  wr_lo,
  input  wire logic [stll_pkg::LABEL_HIGH_W-1:0] wr_hi,
  input  wire logic [stll_pkg::ADDR_W-1:0]       wr_addr
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

  logic                              valid;
  logic [stll_pkg::LABEL_LOW_W-1:0]  label_lo;
  logic [stll_pkg::LABEL_HIGH_W-1:0] label_hi;
  logic [stll_pkg::ADDR_W-1:0]       addr;

  logic                  match;
  logic                  new_match;
  logic                  sel;
  stll_pkg::scan_flags_t flags_next;

  assign match     = valid && (label_lo == req_lo) && (label_hi == req_hi);
  assign new_match = valid && (label_lo == new_lo) && (label_hi == new_hi);
  assign sel       = (wr_idx == MY_IDX);

  always_comb begin
    flags_next.hit   = flags_in.hit   | match;
    flags_next.free  = flags_in.free  | !valid;
    flags_next.other = flags_in.other | new_match;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= 1'b0;
    end else begin
      tok_out <= tok_in;
    end
  end

  // keep the first (lowest) index seen for each flag
  always_ff @(posedge clk) begin
    flags_out     <= flags_next;
    hit_idx_out   <= flags_in.hit   ? hit_idx_in   : MY_IDX;
    free_idx_out  <= flags_in.free  ? free_idx_in  : MY_IDX;
    other_idx_out <= flags_in.other ? other_idx_in : MY_IDX;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (sel) begin
      if (wr_cmd.set_valid) begin
        valid <= 1'b1;
      end else if (wr_cmd.clr_valid) begin
        valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sel && wr_cmd.wr_label) begin
      label_lo <= wr_lo;
      label_hi <= wr_hi;
    end
    if (sel && wr_cmd.wr_addr) begin
      addr <= wr_addr;
    end
  end

endmodule

`default_nettype wire

// File: rtl/symbol_table_label_lookup_core.sv
// Top level of the symbol table: request control, chain of slot cells, result register.
//
// Symbol table of ENTRIES labels (nine bytes each) mapped to 16-bit addresses.
// Request channel: in_valid/in_ready with func, label, new label and address.
// Result channel: out_valid/out_ready with a 2-bit status.
// One request is handled at a time. After acceptance a scan token walks the
// row of slot cells, one cell per cycle, collecting the hit, first free slot
// and new-label hit; then one commit cycle updates the chosen slot and loads
// the status register. The wait from acceptance to out_valid, and between
// requests, is set by the length of the cell chain.
// in_ready is high only while no request is in flight; it may rise while a
// status word still waits in the output register.
// If the receiver stalls, the next request scans normally and then holds in
// its commit cycle, leaving the table unchanged, until the status word ahead
// of it is taken.
// Reset clears every slot's valid bit at once; the block is ready on the
// first cycle after reset.
`default_nettype none

module symbol_table_label_lookup_core #(
  parameter int ENTRIES = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  func,
  input  wire logic [63:0] label_low,
  input  wire logic [7:0]  label_high,
  input  wire logic [63:0] new_label_low,
  input  wire logic [7:0]  new_label_high,
  input  wire logic [15:0] address,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       status
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  // request registers
  stll_pkg::func_t                   req_func;
  logic [stll_pkg::LABEL_LOW_W-1:0]  req_lo;
  logic [stll_pkg::LABEL_HIGH_W-1:0] req_hi;
  logic [stll_pkg::LABEL_LOW_W-1:0]  req_new_lo;
  logic [stll_pkg::LABEL_HIGH_W-1:0] req_new_hi;
  logic [stll_pkg::ADDR_W-1:0]       req_addr;

  stll_pkg::state_t state;
  stll_pkg::state_t state_next;
  logic             launch;

  // chain links
  logic                  tok       [0:ENTRIES];
  stll_pkg::scan_flags_t flags     [0:ENTRIES];
  logic [IDX_W-1:0]      hit_idx   [0:ENTRIES];
  logic [IDX_W-1:0]      free_idx  [0:ENTRIES];
  logic [IDX_W-1:0]      other_idx [0:ENTRIES];
  logic [ENTRIES-1:0]    tok_vec;

  // scan results
  stll_pkg::scan_flags_t res_flags;
  logic [IDX_W-1:0]      res_hit_idx;
  logic [IDX_W-1:0]      res_free_idx;
  logic [IDX_W-1:0]      res_other_idx;

  // commit
  logic                              accept;
  logic                              out_free;
  logic                              commit;
  stll_pkg::stat_t                   stat;
  stll_pkg::wr_cmd_t                 cmd;
  stll_pkg::wr_cmd_t                 wr_cmd;
  logic [IDX_W-1:0]                  wr_idx;
  logic [stll_pkg::LABEL_LOW_W-1:0]  wr_lo;
  logic [stll_pkg::LABEL_HIGH_W-1:0] wr_hi;

  assign in_ready = (state == stll_pkg::ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign commit   = (state == stll_pkg::ST_COMMIT) && out_free;

  // token enters the chain with empty results
  assign tok[0]       = launch;
  assign flags[0]     = '0;
  assign hit_idx[0]   = '0;
  assign free_idx[0]  = '0;
  assign other_idx[0] = '0;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    assign tok_vec[g] = tok[g+1];

    stll_cell #(
      .ENTRIES (ENTRIES),
      .INDEX   (g)
    ) u_cell (
      .clk           (clk),
      .rst           (rst),
      .tok_in        (tok[g]),
      .flags_in      (flags[g]),
      .hit_idx_in    (hit_idx[g]),
      .free_idx_in   (free_idx[g]),
      .other_idx_in  (other_idx[g]),
      .tok_out       (tok[g+1]),
      .flags_out     (flags[g+1]),
      .hit_idx_out   (hit_idx[g+1]),
      .free_idx_out  (free_idx[g+1]),
      .other_idx_out (other_idx[g+1]),
      .req_lo        (req_lo),
      .req_hi        (req_hi),
      .new_lo        (req_new_lo),
      .new_hi        (req_new_hi),
      .wr_cmd        (wr_cmd),
      .wr_idx        (wr_idx),
      .wr_lo         (wr_lo),
      .wr_hi         (wr_hi),
      .wr_addr       (req_addr)
    );
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_func   <= stll_pkg::func_t'(func);
      req_lo     <= label_low;
      req_hi     <= label_high;
      req_new_lo <= new_label_low;
      req_new_hi <= new_label_high;
      req_addr   <= address;
    end
  end

  always_ff @(posedge clk) begin
    if (tok[ENTRIES]) begin
      res_flags     <= flags[ENTRIES];
      res_hit_idx   <= hit_idx[ENTRIES];
      res_free_idx  <= free_idx[ENTRIES];
      res_other_idx <= other_idx[ENTRIES];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= stll_pkg::ST_IDLE;
      launch <= 1'b0;
    end else begin
      state  <= state_next;
      launch <= accept;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      stll_pkg::ST_IDLE: begin
        if (accept) state_next = stll_pkg::ST_SCAN;
      end
      stll_pkg::ST_SCAN: begin
        if (tok[ENTRIES]) state_next = stll_pkg::ST_COMMIT;
      end
      stll_pkg::ST_COMMIT: begin
        if (out_free) state_next = stll_pkg::ST_IDLE;
      end
      default: state_next = stll_pkg::ST_IDLE;
    endcase
  end

  // decide status and the slot update from the scan results
  always_comb begin
    stat   = stll_pkg::STAT_OK;
    cmd    = '0;
    wr_idx = res_hit_idx;
    wr_lo  = req_lo;
    wr_hi  = req_hi;
    case (req_func)
      stll_pkg::FUNC_INSERT: begin
        if (res_flags.hit) begin
          stat = stll_pkg::STAT_DUP;
        end else if (!res_flags.free) begin
          stat = stll_pkg::STAT_FULL;
        end else begin
          cmd.set_valid = 1'b1;
          cmd.wr_label  = 1'b1;
          cmd.wr_addr   = 1'b1;
          wr_idx        = res_free_idx;
        end
      end
      stll_pkg::FUNC_DELETE: begin
        if (!res_flags.hit) stat = stll_pkg::STAT_MISSING;
        else cmd.clr_valid = 1'b1;
      end
      stll_pkg::FUNC_SEARCH: begin
        if (!res_flags.hit) stat = stll_pkg::STAT_MISSING;
      end
      stll_pkg::FUNC_RENAME, stll_pkg::FUNC_RENAME_ADDR: begin
        if (!res_flags.hit) begin
          stat = stll_pkg::STAT_MISSING;
        end else if (res_flags.other && (res_other_idx != res_hit_idx)) begin
          stat = stll_pkg::STAT_DUP;
        end else begin
          cmd.wr_label = 1'b1;
          cmd.wr_addr  = (req_func == stll_pkg::FUNC_RENAME_ADDR);
          wr_lo        = req_new_lo;
          wr_hi        = req_new_hi;
        end
      end
      stll_pkg::FUNC_SET_ADDR: begin
        if (!res_flags.hit) stat = stll_pkg::STAT_MISSING;
        else cmd.wr_addr = 1'b1;
      end
      default: ;
    endcase
    wr_cmd = commit ? cmd : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      status <= stat;
    end
  end

`include "symbol_table_label_lookup_core_assert.svh"

  `STLL_ASSERT_NOW(a_one_token, 1'b1, $onehot0(tok_vec), "more than one scan token in chain")
  `STLL_ASSERT_NOW(a_token_in_scan, tok[ENTRIES], state == stll_pkg::ST_SCAN,
                   "scan token left chain outside scan")
  `STLL_ASSERT_NEXT(a_accept_scan, accept, (state == stll_pkg::ST_SCAN) && launch,
                    "accepted request did not launch a scan")
  `STLL_ASSERT_NEXT(a_commit_out, commit, out_valid && (state == stll_pkg::ST_IDLE),
                    "commit did not load the status word")

endmodule

`default_nettype wire
